>>> hdl/ntsd_pkg.sv
// Shared constants, codes and cell interface types for the name table block.
package ntsd_pkg;

  localparam int unsigned TableDepthDef = 32;
  localparam int unsigned NameBytesDef  = 30;

  localparam int unsigned StatusW   = 3;
  localparam int unsigned PositionW = 5;
  localparam int unsigned CountW    = 6;
  localparam int unsigned ReqW      = 2;
  localparam int unsigned CharW     = 8;

  localparam logic [ReqW-1:0] REQ_APPEND = 2'd0;
  localparam logic [ReqW-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [ReqW-1:0] REQ_DELETE = 2'd2;

  typedef enum logic [StatusW-1:0] {
    ST_APPENDED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DELETED   = 3'd3,
    ST_FULL      = 3'd4,
    ST_TOO_LONG  = 3'd5
  } status_e;

  // Operations broadcast from the controller to every cell.
  typedef struct packed {
    logic append;
    logic shift;
  } ntsd_ctrl_t;

  // Search outcome reported by a cell while it holds the probe token.
  typedef struct packed {
    logic hit;
    logic miss;
  } ntsd_stat_t;

endpackage

>>> hdl/ntsd_key.sv
// Assembles the incoming name byte by byte and tracks the length limit.
module ntsd_key import ntsd_pkg::*; #(
  parameter int unsigned NameBytes = NameBytesDef,
  localparam int unsigned KeyLen = NameBytes - 1,
  localparam int unsigned KeyW   = 8 * KeyLen
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             byte_en_i,
  input  logic [CharW-1:0] name_char_i,
  input  logic             clear_i,
  output logic [KeyW-1:0]  key_o,
  output logic             too_long_o
);

  localparam int unsigned IdxW = $clog2(KeyLen + 1);

  logic [KeyW-1:0]  key_q, key_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             term_q, term_d;
  logic             long_q, long_d;
  logic [CharW-1:0] byte_in;

  // Once a zero byte has been stored the name has ended; later bytes read as zero.
  assign byte_in = term_q ? '0 : name_char_i;

  always_comb begin
    key_d  = key_q;
    idx_d  = idx_q;
    term_d = term_q;
    long_d = long_q;
    if (clear_i) begin
      key_d  = '0;
      idx_d  = '0;
      term_d = 1'b0;
      long_d = 1'b0;
    end else if (byte_en_i) begin
      if (idx_q < IdxW'(KeyLen)) begin
        for (int j = 0; j < KeyLen; j++) begin
          if (idx_q == IdxW'(j)) begin
            key_d[8*j +: 8] = byte_in;
          end
        end
        idx_d  = idx_q + IdxW'(1);
        term_d = term_q | (byte_in == '0);
      end else begin
        long_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      idx_q  <= '0;
      term_q <= 1'b0;
      long_q <= 1'b0;
    end else begin
      key_q  <= key_d;
      idx_q  <= idx_d;
      term_q <= term_d;
      long_q <= long_d;
    end
  end

  assign key_o      = key_q;
  assign too_long_o = long_q;

endmodule

>>> hdl/ntsd_cell.sv
// One table slot: holds a stored name, compares it when the probe token arrives.
module ntsd_cell import ntsd_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDef,
  parameter int unsigned KeyW       = 8 * (NameBytesDef - 1),
  parameter int unsigned Idx        = 0,
  localparam int unsigned CntW = $clog2(TableDepth + 1),
  localparam int unsigned IdxW = $clog2(TableDepth)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ntsd_ctrl_t      ctrl_i,
  input  logic [CntW-1:0] fill_count_i,
  input  logic [IdxW-1:0] del_pos_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [KeyW-1:0] next_entry_i,
  output logic [KeyW-1:0] entry_o,
  input  logic            token_i,
  output logic            token_o,
  output ntsd_stat_t      stat_o
);

  logic [KeyW-1:0] entry_q;
  logic            token_q;
  logic            occupied;
  logic            match;

  assign occupied = CntW'(Idx) < fill_count_i;
  assign match    = entry_q == key_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.append && (fill_count_i == CntW'(Idx))) begin
      entry_q <= key_i;
    end else if (ctrl_i.shift && (del_pos_i <= IdxW'(Idx))) begin
      entry_q <= next_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= 1'b0;
    end else begin
      token_q <= token_i;
    end
  end

  assign token_o     = token_q & occupied & ~match;
  assign stat_o.hit  = token_q & occupied & match;
  assign stat_o.miss = token_q & ~occupied;
  assign entry_o     = entry_q;

endmodule

>>> hdl/name_table_search_delete.sv
// Top level of the name table: byte assembler, controller and the row of table cells.
//
// Usage: a name is presented one byte per transaction on name_char_i; a
// transaction is taken at a rising edge with start high and busy low. The byte
// with char_last_i high ends the name, and req_type_i on that byte selects
// append, look up or delete. Non-final bytes are taken back to back, one per
// cycle, and produce no result. After the final byte busy stays high until the
// result has been produced, and exactly one result transaction follows: done_o
// is high for one cycle with status_o, position_o and entry_count_o valid.
// The receiver cannot hold a result off, so there is no stall case.
// Append, table full and name too long are settled in S_EXEC, from which the
// result is registered. Look up and delete pass a probe token down the cell
// chain one cell per cycle, from cell zero until the cell at the hit position
// reports a hit, the first empty cell reports a miss, or the token leaves the
// last cell of a full table; a delete then passes through S_SHIFT, in which
// all later entries move down one slot.
// Reset clears the fill count, the name being received and the controller;
// table slots are not cleared, since only slots below the fill count are read.
module name_table_search_delete import ntsd_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDef,
  parameter int unsigned NameBytes  = NameBytesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [ReqW-1:0]      req_type_i,
  input  logic [CharW-1:0]     name_char_i,
  input  logic                 char_last_i,
  output logic                 done_o,
  output logic [StatusW-1:0]   status_o,
  output logic [PositionW-1:0] position_o,
  output logic [CountW-1:0]    entry_count_o
);

  localparam int unsigned KeyW = 8 * (NameBytes - 1);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned IdxW = $clog2(TableDepth);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT
  } state_e;

  state_e               state_q;
  logic [ReqW-1:0]      req_q;
  logic [CntW-1:0]      fill_q;
  logic [IdxW-1:0]      scan_q;
  logic [IdxW-1:0]      pos_q;
  logic                 done_q;
  status_e              status_q;
  logic [PositionW-1:0] position_q;
  logic [CountW-1:0]    count_q;

  logic            accept;
  logic            too_long;
  logic [KeyW-1:0] key;
  logic            key_clear;
  logic            launch;
  logic            table_full;
  logic            any_hit;
  logic            any_miss;
  ntsd_ctrl_t      ctrl;

  logic [KeyW-1:0] entry [TableDepth];
  logic [TableDepth:0] token;
  ntsd_stat_t      stat [TableDepth];
  logic [TableDepth-1:0] hit_vec;

  assign busy   = state_q != S_IDLE;
  assign accept = start && !busy;

  ntsd_key #(
    .NameBytes(NameBytes)
  ) u_key (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_en_i  (accept),
    .name_char_i(name_char_i),
    .clear_i    (key_clear),
    .key_o      (key),
    .too_long_o (too_long)
  );

  assign table_full  = fill_q >= CntW'(TableDepth);
  // The probe token enters cell zero when a search starts.
  assign launch      = (state_q == S_EXEC) && !too_long && (req_q != REQ_APPEND);
  assign ctrl.append = (state_q == S_EXEC) && !too_long && (req_q == REQ_APPEND) &&
                       !table_full;
  assign ctrl.shift  = state_q == S_SHIFT;
  assign token[0]    = launch;

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    logic [KeyW-1:0] next_entry;
    if (i == TableDepth - 1) begin : g_last
      assign next_entry = entry[i];
    end else begin : g_mid
      assign next_entry = entry[i+1];
    end
    ntsd_cell #(
      .TableDepth(TableDepth),
      .KeyW      (KeyW),
      .Idx       (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .fill_count_i(fill_q),
      .del_pos_i   (pos_q),
      .key_i       (key),
      .next_entry_i(next_entry),
      .entry_o     (entry[i]),
      .token_i     (token[i]),
      .token_o     (token[i+1]),
      .stat_o      (stat[i])
    );
  end

  // Only one cell holds the token, so the hit flags are a plain OR. A token that
  // leaves the last cell without a hit means the whole table missed.
  always_comb begin
    any_miss = token[TableDepth];
    for (int i = 0; i < TableDepth; i++) begin
      hit_vec[i] = stat[i].hit;
      any_miss   = any_miss | stat[i].miss;
    end
    any_hit = |hit_vec;
  end

  // The received name is dropped when the request completes.
  always_comb begin
    key_clear = 1'b0;
    case (state_q)
      S_EXEC:  key_clear = too_long || (req_q == REQ_APPEND);
      S_SCAN:  key_clear = (any_hit && (req_q != REQ_DELETE)) || (!any_hit && any_miss);
      S_SHIFT: key_clear = 1'b1;
      default: key_clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      req_q      <= REQ_APPEND;
      fill_q     <= '0;
      scan_q     <= '0;
      pos_q      <= '0;
      done_q     <= 1'b0;
      status_q   <= ST_APPENDED;
      position_q <= '0;
      count_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept && char_last_i) begin
            req_q   <= req_type_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (too_long) begin
            done_q     <= 1'b1;
            status_q   <= ST_TOO_LONG;
            position_q <= '0;
            count_q    <= CountW'(fill_q);
            state_q    <= S_IDLE;
          end else if (req_q == REQ_APPEND) begin
            done_q <= 1'b1;
            if (!table_full) begin
              fill_q     <= fill_q + CntW'(1);
              status_q   <= ST_APPENDED;
              position_q <= PositionW'(fill_q);
              count_q    <= CountW'(fill_q + CntW'(1));
            end else begin
              status_q   <= ST_FULL;
              position_q <= '0;
              count_q    <= CountW'(fill_q);
            end
            state_q <= S_IDLE;
          end else begin
            scan_q  <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (any_hit) begin
            pos_q <= scan_q;
            if (req_q == REQ_DELETE) begin
              state_q <= S_SHIFT;
            end else begin
              done_q     <= 1'b1;
              status_q   <= ST_FOUND;
              position_q <= PositionW'(scan_q);
              count_q    <= CountW'(fill_q);
              state_q    <= S_IDLE;
            end
          end else if (any_miss) begin
            done_q     <= 1'b1;
            status_q   <= ST_NOT_FOUND;
            position_q <= '0;
            count_q    <= CountW'(fill_q);
            state_q    <= S_IDLE;
          end else begin
            scan_q <= scan_q + IdxW'(1);
          end
        end
        S_SHIFT: begin
          fill_q     <= fill_q - CntW'(1);
          done_q     <= 1'b1;
          status_q   <= ST_DELETED;
          position_q <= PositionW'(pos_q);
          count_q    <= CountW'(fill_q - CntW'(1));
          state_q    <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign position_o    = position_q;
  assign entry_count_o = count_q;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(TableDepth))
    else $error("fill count exceeds table depth");

  a_hit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (any_hit || any_miss) |-> (state_q == S_SCAN && $onehot0(hit_vec)))
    else $error("search outcome outside a scan or from more than one cell");

  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && char_last_i))
    else $error("request started without a final byte");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result issued while a request is still running");
`endif

endmodule
